FILE: src/bssd_pkg.sv
`timescale 1ns / 1ps

package bssd_pkg;

    localparam int PAGE_W      = 16;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH = 3'b001,
        OP_POP  = 3'b010,
        OP_LIST = 3'b100
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PAGE_W-1:0] page;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

FILE: src/bssd_front.sv
`timescale 1ns / 1ps

module bssd_front
    import bssd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PAGE_W-1:0] s_tdata,   // [15:0] page
    input  logic [KIND_W-1:0] s_tuser,   // [1:0] kind
    output logic              q_valid,
    input  logic              q_ready,
    output cmd_t              q_cmd
);

    cmd_t              buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              keep;
    logic              wr_en;
    logic              rd_en;
    cmd_t              cmd_in;

    // decode the kind; an unused kind is taken and dropped here
    always_comb begin
        cmd_in.page = s_tdata;
        keep        = 1'b1;
        case (s_tuser)
            KIND_PUSH: cmd_in.op = OP_PUSH;
            KIND_POP:  cmd_in.op = OP_POP;
            KIND_LIST: cmd_in.op = OP_LIST;
            default: begin
                cmd_in.op = OP_POP;
                keep      = 1'b0;
            end
        endcase
    end

    assign s_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = buf_reg[rd_ptr_reg];
    assign wr_en    = s_tvalid && s_tready && keep;
    assign rd_en    = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(rd_en);
        cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == QCNT_W'(QUEUE_DEPTH) |=> !(cnt_reg == QCNT_W'(0)) || $past(rd_en))
        else $error("queue count jumped from full to empty");
    a_drop_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !keep && !rd_en) |=> $stable(cnt_reg))
        else $error("unused kind entered the queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

FILE: src/bssd_back.sv
`timescale 1ns / 1ps

module bssd_back
    import bssd_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_t              q_cmd,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PAGE_W-1:0] m_tdata,   // [15:0] page_out
    output logic              m_tlast,   // last
    output logic              m_tuser    // [0] empty_res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = PAGE_W + IDX_W;

    logic [PAGE_W-1:0] mem [DEPTH];
    logic [PAGE_W-1:0] mem_q;
    logic              mem_we;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [CNT_W-1:0]  emitted_reg, emitted_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic              best_vld_reg, best_vld_next;
    logic [KEY_W-1:0]  last_key_reg, last_key_next;
    logic              first_reg, first_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [PAGE_W-1:0] out_page_reg, out_page_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;

    logic              out_free;
    logic [KEY_W-1:0]  cand_key;
    logic              cand_take;
    logic              final_one;

    assign out_free  = !m_tvalid_reg || m_tready;
    // (value, slot) key keeps duplicates apart and ordered
    assign cand_key  = {mem_q, rd_idx_reg};
    assign cand_take = rd_pend_reg && (first_reg || cand_key > last_key_reg)
                       && (!best_vld_reg || cand_key < best_key_reg);
    assign final_one = (emitted_reg + CNT_W'(1)) == count_reg;
    assign rd_addr   = issue_reg[IDX_W-1:0];
    assign wr_addr   = count_reg[IDX_W-1:0];

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        emitted_next   = emitted_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_key_next  = best_key_reg;
        best_vld_next  = best_vld_reg;
        last_key_next  = last_key_reg;
        first_next     = first_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_page_next  = out_page_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        q_ready        = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                q_ready = (q_cmd.op != OP_LIST) || (count_reg != '0) || out_free;
                if (q_valid) begin
                    case (q_cmd.op)
                        OP_PUSH: begin
                            if (count_reg < CNT_W'(DEPTH)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (count_reg != '0) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                if (out_free) begin
                                    m_tvalid_next  = 1'b1;
                                    out_page_next  = '0;
                                    out_last_next  = 1'b1;
                                    out_empty_next = 1'b1;
                                end
                            end else begin
                                state_next    = ST_SCAN;
                                issue_next    = '0;
                                emitted_next  = '0;
                                best_vld_next = 1'b0;
                                first_next    = 1'b1;
                            end
                        end
                        default: begin
                            q_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue_reg != count_reg) begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end else if (!rd_pend_reg) begin
                    state_next = ST_EMIT;
                end
                if (cand_take) begin
                    best_key_next = cand_key;
                    best_vld_next = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_page_next  = best_key_reg[KEY_W-1:IDX_W];
                    out_last_next  = final_one;
                    out_empty_next = 1'b0;
                    emitted_next   = emitted_reg + CNT_W'(1);
                    last_key_next  = best_key_reg;
                    first_next     = 1'b0;
                    best_vld_next  = 1'b0;
                    issue_next     = '0;
                    state_next     = final_one ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            emitted_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            emitted_reg  <= emitted_next;
            rd_pend_reg  <= rd_pend_next;
            best_vld_reg <= best_vld_next;
            first_reg    <= first_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        best_key_reg  <= best_key_next;
        last_key_reg  <= last_key_next;
        out_page_reg  <= out_page_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_cmd.page;
        end
        mem_q <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_page_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty result not marked last");
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (count_reg != '0 && emitted_reg < count_reg))
        else $error("listing with nothing left to emit");
    a_emit_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> best_vld_reg)
        else $error("emit without a selected entry");
    a_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("fill count changed during listing");
`endif

endmodule

FILE: src/bounded_stack_sorted_dump_top.sv
`timescale 1ns / 1ps
// push and pop: one item per cycle sustained while no list runs; stack updated from the queue
// list of n entries: each result takes one scan of the entry store plus an emit step,
// the scan set by the single read port of the store, the emit held until the output is free
// list on an empty stack: one result, with empty_res and last set
// aresetn (synchronous, active low) empties the stack and queue; store contents are not cleared

module bounded_stack_sorted_dump_top
    import bssd_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PAGE_W-1:0] s_tdata,   // [15:0] page
    input  logic [KIND_W-1:0] s_tuser,   // [1:0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PAGE_W-1:0] m_tdata,   // [15:0] page_out
    output logic              m_tlast,
    output logic              m_tuser    // [0] empty_res
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    bssd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    bssd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
